/* rtl/collider_table_overlap_sweep_defines.svh */
// ---------------------------------------------------------------------------
// collider table overlap sweep: assertion macros
// shared checking shorthands for the collider table rtl
// ---------------------------------------------------------------------------
`ifndef COLLIDER_TABLE_OVERLAP_SWEEP_DEFINES_SVH
`define COLLIDER_TABLE_OVERLAP_SWEEP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CTOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CTOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ctos_pkg.sv */
// ---------------------------------------------------------------------------
// ctos_pkg
// types, codes and sizes shared by the collider table rtl
// ---------------------------------------------------------------------------
package ctos_pkg;

    // table size and derived widths
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_SWEEP = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // entry kinds
    localparam logic [1:0] KIND_PLAYER = 2'd0;
    localparam logic [1:0] KIND_GROUND = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;
    localparam logic [1:0] KIND_WIN    = 2'd3;

    // player/ground, ground/player and none/ground enabled after reset
    localparam logic [15:0] PAIR_ENABLE_RESET = 16'd530;

    typedef struct packed {
        logic        [14:0] h;
        logic        [14:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_rect;

    typedef struct packed {
        t_rect       rect;
        logic [1:0]  kind;
        logic        notify;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* rtl/ctos_ram.sv */
// ---------------------------------------------------------------------------
// ctos_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module ctos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ctos_overlap.sv */
// ---------------------------------------------------------------------------
// ctos_overlap
// strict overlap test of two axis-aligned rectangles
// ---------------------------------------------------------------------------
module ctos_overlap (
    input  ctos_pkg::t_rect i_a,
    input  ctos_pkg::t_rect i_b,
    output logic            o_overlap
);

    logic signed [16:0] ax, ay, bx, by;
    logic signed [16:0] ax_end, ay_end, bx_end, by_end;

    // sign-extend edges, zero-extend extents by two bits so sums cannot wrap
    assign ax = {i_a.x[15], i_a.x};
    assign ay = {i_a.y[15], i_a.y};
    assign bx = {i_b.x[15], i_b.x};
    assign by = {i_b.y[15], i_b.y};

    assign ax_end = ax + $signed({2'b00, i_a.w});
    assign ay_end = ay + $signed({2'b00, i_a.h});
    assign bx_end = bx + $signed({2'b00, i_b.w});
    assign by_end = by + $signed({2'b00, i_b.h});

    // touching edges do not count
    assign o_overlap = !((by_end <= ay) || (by >= ay_end) ||
                         (bx_end <= ax) || (bx >= ax_end));

endmodule

/* rtl/collider_table_overlap_sweep.sv */
// ---------------------------------------------------------------------------
// collider_table_overlap_sweep
// table of rectangles with add, mark, clear and an overlap sweep
// ---------------------------------------------------------------------------
// Usage: commands arrive on the input channel (i_in_valid / o_in_stall) with
// the rectangle, kind, notify and slot fields. Results leave on the output
// channel (o_out_valid / i_out_stall) through one output register; the final
// result of every command has o_last set. The pair enable register is written
// through i_cfg_valid / o_cfg_ready, which is always ready; write it only
// while no command is in flight.
// Sequence: add, mark and clear each give a single result, loaded into the
// output register from the single state once that register is free. A sweep
// first frees marked slots, then steps through the source slots; an occupied
// source is read through the registered ram read, and a reporting source then
// steps through every slot, reading each other occupied slot for the overlap
// test and giving one result per reported pair, then a final result. The table
// ram's single read port paces the sweep.
// The block takes one command at a time; o_in_stall is high until the last
// result has been placed in the output register.
// Reset empties the table and restores the pair enable register. While the
// receiver stalls, the result is held and the sequencer waits before loading the next.
// ---------------------------------------------------------------------------
`include "collider_table_overlap_sweep_defines.svh"

module collider_table_overlap_sweep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic [14:0]        i_rect_w,
    input  logic [14:0]        i_rect_h,
    input  logic [1:0]         i_kind,
    input  logic               i_notify,
    input  logic [2:0]         i_slot_sel,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [2:0]         o_slot_out,
    output logic               o_hit_valid,
    output logic [2:0]         o_source_slot,
    output logic [2:0]         o_other_slot,
    output logic               o_last,
    output logic [3:0]         o_occupied_count,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_pair_enable
);

    localparam int SLOTS  = ctos_pkg::SLOTS;
    localparam int SLOT_W = ctos_pkg::SLOT_W;
    localparam int CNT_W  = ctos_pkg::CNT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SINGLE  = 4'd1;
    localparam logic [3:0] S_FREE    = 4'd2;
    localparam logic [3:0] S_SRC_RD  = 4'd3;
    localparam logic [3:0] S_SRC_LAT = 4'd4;
    localparam logic [3:0] S_OTH_RD  = 4'd5;
    localparam logic [3:0] S_OTH_CMP = 4'd6;
    localparam logic [3:0] S_HIT     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [SLOTS-1:0]       r_occupied, n_occupied;
    logic [SLOTS-1:0]       r_pending, n_pending;
    logic [15:0]            r_pair_enable;
    logic [1:0]             r_cmd, n_cmd;
    ctos_pkg::t_entry       r_entry, n_entry;
    logic [2:0]             r_slot_sel, n_slot_sel;
    ctos_pkg::t_entry       r_src, n_src;

    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_status, n_status;
    logic [2:0]             r_slot_out, n_slot_out;
    logic                   r_hit_valid, n_hit_valid;
    logic [2:0]             r_source_slot, n_source_slot;
    logic [2:0]             r_other_slot, n_other_slot;
    logic                   r_last, n_last;
    logic [3:0]             r_count, n_count;

    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_free_found;
    logic [SLOT_W-1:0]      w_free_idx;
    logic                   w_sel_ok;
    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [SLOT_W-1:0]      w_ram_raddr;
    logic [ctos_pkg::ENTRY_W-1:0] w_ram_rdata;
    ctos_pkg::t_entry       w_rd;
    logic                   w_overlap;

    // entry table
    ctos_ram #(
        .WIDTH (ctos_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_free_idx),
        .i_wdata (r_entry),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd = ctos_pkg::t_entry'(w_ram_rdata);

    // shared overlap unit: held source against the entry just read
    ctos_overlap u_overlap (
        .i_a       (r_src.rect),
        .i_b       (w_rd.rect),
        .o_overlap (w_overlap)
    );

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_occupied[k]) begin
                w_free_found = 1'b1;
                w_free_idx   = SLOT_W'(k);
            end
        end
    end

    assign w_sel_ok = ({1'b0, r_slot_sel} < 4'(SLOTS)) &&
                      r_occupied[r_slot_sel[SLOT_W-1:0]];

    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        n_occupied    = r_occupied;
        n_pending     = r_pending;
        n_cmd         = r_cmd;
        n_entry       = r_entry;
        n_slot_sel    = r_slot_sel;
        n_src         = r_src;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;
        w_ram_raddr   = r_i[SLOT_W-1:0];
        w_out_load    = 1'b0;
        n_status      = ctos_pkg::STATUS_DONE;
        n_slot_out    = '0;
        n_hit_valid   = 1'b0;
        n_source_slot = '0;
        n_other_slot  = '0;
        n_last        = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd            = i_command;
                    n_entry.rect.x   = i_rect_x;
                    n_entry.rect.y   = i_rect_y;
                    n_entry.rect.w   = i_rect_w;
                    n_entry.rect.h   = i_rect_h;
                    n_entry.kind     = i_kind;
                    n_entry.notify   = i_notify;
                    n_slot_sel       = i_slot_sel;
                    n_state = (i_command == ctos_pkg::CMD_SWEEP) ? S_FREE : S_SINGLE;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    case (r_cmd)
                        ctos_pkg::CMD_ADD: begin
                            if (w_free_found) begin
                                w_ram_we               = 1'b1;
                                n_occupied[w_free_idx] = 1'b1;
                                n_pending[w_free_idx]  = 1'b0;
                                n_slot_out             = 3'(w_free_idx);
                            end else begin
                                n_status = ctos_pkg::STATUS_FULL;
                            end
                        end
                        ctos_pkg::CMD_MARK: begin
                            if (w_sel_ok) begin
                                n_pending[r_slot_sel[SLOT_W-1:0]] = 1'b1;
                            end else begin
                                n_status = ctos_pkg::STATUS_EMPTY;
                            end
                        end
                        ctos_pkg::CMD_CLEAR: begin
                            n_occupied = '0;
                            n_pending  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // free every marked slot before testing
            S_FREE: begin
                n_occupied = r_occupied & ~r_pending;
                n_pending  = '0;
                n_i        = '0;
                n_state    = S_SRC_RD;
            end
            S_SRC_RD: begin
                if (r_i == CNT_W'(SLOTS)) begin
                    n_state = S_DONE;
                end else if (!r_occupied[r_i[SLOT_W-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    w_ram_re    = 1'b1;
                    w_ram_raddr = r_i[SLOT_W-1:0];
                    n_state     = S_SRC_LAT;
                end
            end
            // only player and none entries that want reports act as sources
            S_SRC_LAT: begin
                n_src = w_rd;
                if ((w_rd.kind inside {ctos_pkg::KIND_PLAYER, ctos_pkg::KIND_NONE}) &&
                    w_rd.notify) begin
                    n_j     = '0;
                    n_state = S_OTH_RD;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SRC_RD;
                end
            end
            S_OTH_RD: begin
                if (r_j == CNT_W'(SLOTS)) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SRC_RD;
                end else if (!r_occupied[r_j[SLOT_W-1:0]] || (r_j == r_i)) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    w_ram_re    = 1'b1;
                    w_ram_raddr = r_j[SLOT_W-1:0];
                    n_state     = S_OTH_CMP;
                end
            end
            S_OTH_CMP: begin
                if (w_overlap && r_pair_enable[{r_src.kind, w_rd.kind}]) begin
                    n_state = S_HIT;
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_OTH_RD;
                end
            end
            S_HIT: begin
                if (w_out_free) begin
                    w_out_load    = 1'b1;
                    n_hit_valid   = 1'b1;
                    n_source_slot = 3'(r_i[SLOT_W-1:0]);
                    n_other_slot  = 3'(r_j[SLOT_W-1:0]);
                    n_last        = 1'b0;
                    n_j           = r_j + CNT_W'(1);
                    n_state       = S_OTH_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count = 4'($countones(n_occupied));

        // output register load or drain
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_occupied    <= '0;
            r_pending     <= '0;
            r_pair_enable <= ctos_pkg::PAIR_ENABLE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occupied  <= n_occupied;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_pair_enable <= i_cfg_pair_enable;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_cmd      <= n_cmd;
        r_entry    <= n_entry;
        r_slot_sel <= n_slot_sel;
        r_src      <= n_src;
        if (w_out_load) begin
            r_status      <= n_status;
            r_slot_out    <= n_slot_out;
            r_hit_valid   <= n_hit_valid;
            r_source_slot <= n_source_slot;
            r_other_slot  <= n_other_slot;
            r_last        <= n_last;
            r_count       <= n_count;
        end
    end

    // ports
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_slot_out       = r_slot_out;
    assign o_hit_valid      = r_hit_valid;
    assign o_source_slot    = r_source_slot;
    assign o_other_slot     = r_other_slot;
    assign o_last           = r_last;
    assign o_occupied_count = r_count;

    // checks
    `CTOS_ASSERT_NOW(a_pending_occupied, 1'b1, (r_pending & ~r_occupied) == '0,
                     "mark on free slot")
    `CTOS_ASSERT_NOW(a_hit_distinct, r_out_valid && r_hit_valid,
                     (r_source_slot != r_other_slot) && !r_last, "bad pair result")
    `CTOS_ASSERT_NEXT(a_accept_busy, (r_state == S_IDLE) && i_in_valid,
                      r_state != S_IDLE, "command not taken")
    `CTOS_ASSERT_NEXT(a_last_idle, w_out_load && n_last, r_state == S_IDLE,
                      "last result left block busy")

endmodule
